// ===== rtl/core/fixed_point_alu_top_assert.svh =====
// Assertion macros shared by the fixed-point ALU RTL.
`ifndef FIXED_POINT_ALU_TOP_ASSERT_SVH
`define FIXED_POINT_ALU_TOP_ASSERT_SVH

// Check a property on every clock edge outside reset.
`define FPA_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Check that a condition in one cycle implies another in the next cycle.
`define FPA_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fpa_pkg.sv =====
// Shared operation codes and control types for the fixed-point ALU.
`timescale 1ns / 1ps

package fpa_pkg;

	localparam int CMD_W = 3;

	localparam logic [CMD_W-1:0] CMD_NEG = 3'd0;
	localparam logic [CMD_W-1:0] CMD_ADD = 3'd1;
	localparam logic [CMD_W-1:0] CMD_SUB = 3'd2;
	localparam logic [CMD_W-1:0] CMD_INC = 3'd3;
	localparam logic [CMD_W-1:0] CMD_DEC = 3'd4;
	localparam logic [CMD_W-1:0] CMD_MUL = 3'd5;
	localparam logic [CMD_W-1:0] CMD_DIV = 3'd6;

	// Control bits that travel alongside each word through the pipeline
	typedef struct packed {
		logic valid;
		logic is_div;
		logic dz;
		logic neg;
	} fpa_ctl_t;

endpackage

// ===== rtl/core/fpa_front.sv =====
// First stage: simple operations, multiply and divider operand setup.
`timescale 1ns / 1ps

module fpa_front #(
	parameter int WIDTH     = 16,
	parameter int FRAC_BITS = 8
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           adv,
	input  logic                           valid,
	input  logic [fpa_pkg::CMD_W-1:0]      cmd,
	input  logic signed [WIDTH-1:0]        operand_a,
	input  logic signed [WIDTH-1:0]        operand_b,
	output fpa_pkg::fpa_ctl_t              ctl_s1,
	output logic [WIDTH-1:0]               early_s1,
	output logic [WIDTH+FRAC_BITS-1:0]     num_s1,
	output logic [WIDTH-1:0]               den_s1
);

	localparam int PW = 2 * WIDTH;
	localparam int DW = WIDTH + FRAC_BITS;

	logic signed [PW-1:0]  prod;
	logic signed [PW-1:0]  prod_sh;
	logic [WIDTH-1:0]      early;
	logic [WIDTH-1:0]      abs_a;
	logic [WIDTH-1:0]      abs_b;
	logic                  is_div;

	// Form the full product and drop the fraction bits with sign fill
	assign prod    = PW'(operand_a) * PW'(operand_b);
	assign prod_sh = prod >>> FRAC_BITS;

	// Pick the result of every operation that needs no divider
	always_comb begin
		unique case (cmd)
			fpa_pkg::CMD_NEG: early = WIDTH'(0) - operand_a;
			fpa_pkg::CMD_ADD: early = operand_a + operand_b;
			fpa_pkg::CMD_SUB: early = operand_a - operand_b;
			fpa_pkg::CMD_INC: early = operand_a + WIDTH'(1);
			fpa_pkg::CMD_DEC: early = operand_a - WIDTH'(1);
			fpa_pkg::CMD_MUL: early = prod_sh[WIDTH-1:0];
			default:          early = '0;
		endcase
	end

	// Divide on magnitudes, fix the sign at the end
	assign abs_a  = operand_a[WIDTH-1] ? WIDTH'(0) - operand_a : operand_a;
	assign abs_b  = operand_b[WIDTH-1] ? WIDTH'(0) - operand_b : operand_b;
	assign is_div = (cmd == fpa_pkg::CMD_DIV);

	// Advance the valid and control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_s1 <= '0;
		end else if (adv) begin
			ctl_s1.valid  <= valid;
			ctl_s1.is_div <= is_div;
			ctl_s1.dz     <= is_div && (operand_b == '0);
			ctl_s1.neg    <= operand_a[WIDTH-1] ^ operand_b[WIDTH-1];
		end
	end

	// Capture the word
	always_ff @(posedge clk) begin
		if (adv) begin
			early_s1      <= early;
			num_s1        <= DW'(abs_a) << FRAC_BITS;
			den_s1        <= abs_b;
		end
	end

endmodule

// ===== rtl/core/fpa_div_step.sv =====
// One restoring-division stage: resolves one quotient bit per word.
`timescale 1ns / 1ps

module fpa_div_step #(
	parameter int WIDTH = 16,
	parameter int DW    = 24
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 adv,
	input  fpa_pkg::fpa_ctl_t    ctl,
	input  logic [WIDTH-1:0]     early,
	input  logic [WIDTH-1:0]     rem,
	input  logic [DW-1:0]        qd,
	input  logic [WIDTH-1:0]     den,
	output fpa_pkg::fpa_ctl_t    ctl_sn,
	output logic [WIDTH-1:0]     early_sn,
	output logic [WIDTH-1:0]     rem_sn,
	output logic [DW-1:0]        qd_sn,
	output logic [WIDTH-1:0]     den_sn
);

	logic [WIDTH:0]   trial;
	logic [WIDTH:0]   diff;
	logic             ge;

	// Bring down the next dividend bit and try the subtract
	assign trial = {rem, qd[DW-1]};
	assign diff  = trial - {1'b0, den};
	assign ge    = (trial >= {1'b0, den});

	// Advance the valid and control bits
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ctl_sn <= '0;
		end else if (adv) begin
			ctl_sn <= ctl;
		end
	end

	// Shift the quotient bit in where the dividend bit left
	always_ff @(posedge clk) begin
		if (adv) begin
			early_sn      <= early;
			rem_sn        <= ge ? diff[WIDTH-1:0] : trial[WIDTH-1:0];
			qd_sn         <= {qd[DW-2:0], ge};
			den_sn        <= den;
		end
	end

endmodule

// ===== rtl/core/fixed_point_alu_top.sv =====
// Top level of the pipelined Q-format fixed-point ALU.
//
//   channel | handshake          | payload
//   --------+--------------------+-------------------------------
//   input   | in_valid, in_stall | cmd, operand_a, operand_b
//   output  | out_valid,out_stall| result, divide_by_zero
//
// One word enters per cycle while the output is not stalled.
// The depth is set by the restoring divider, one quotient bit per stage,
// with one setup stage ahead of it and the output register behind it.
// Reset clears only the valid and control bits; data registers load freely.
// A stalled output word freezes the whole pipeline, so nothing is lost.
`timescale 1ns / 1ps

module fixed_point_alu_top #(
	parameter int WIDTH     = 16,
	parameter int FRAC_BITS = 8
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       in_valid,
	output logic                       in_stall,
	input  logic [fpa_pkg::CMD_W-1:0]  cmd,
	input  logic signed [WIDTH-1:0]    operand_a,
	input  logic signed [WIDTH-1:0]    operand_b,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic signed [WIDTH-1:0]    result,
	output logic                       divide_by_zero
);

	localparam int DW = WIDTH + FRAC_BITS;

	fpa_pkg::fpa_ctl_t     ctl_c   [0:DW];
	logic [WIDTH-1:0]      early_c [0:DW];
	logic [WIDTH-1:0]      rem_c   [0:DW];
	logic [DW-1:0]         qd_c    [0:DW];
	logic [WIDTH-1:0]      den_c   [0:DW];

	logic                  adv;
	logic [WIDTH-1:0]      quo;
	logic [WIDTH-1:0]      div_res;
	logic [WIDTH-1:0]      res;
	logic                  out_valid_q;
	logic [WIDTH-1:0]      result_q;
	logic                  divide_by_zero_q;

	// Move the pipeline unless the output word is held
	assign adv      = !(out_valid_q && out_stall);
	assign in_stall = !adv;

	fpa_front #(
		.WIDTH     (WIDTH),
		.FRAC_BITS (FRAC_BITS)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.adv       (adv),
		.valid     (in_valid),
		.cmd       (cmd),
		.operand_a (operand_a),
		.operand_b (operand_b),
		.ctl_s1    (ctl_c[0]),
		.early_s1  (early_c[0]),
		.num_s1    (qd_c[0]),
		.den_s1    (den_c[0])
	);

	assign rem_c[0] = '0;

	// Divider chain, one quotient bit per stage
	for (genvar i = 0; i < DW; i++) begin : g_div
		fpa_div_step #(
			.WIDTH (WIDTH),
			.DW    (DW)
		) u_step (
			.clk      (clk),
			.arst_n   (arst_n),
			.adv      (adv),
			.ctl      (ctl_c[i]),
			.early    (early_c[i]),
			.rem      (rem_c[i]),
			.qd       (qd_c[i]),
			.den      (den_c[i]),
			.ctl_sn   (ctl_c[i+1]),
			.early_sn (early_c[i+1]),
			.rem_sn   (rem_c[i+1]),
			.qd_sn    (qd_c[i+1]),
			.den_sn   (den_c[i+1])
		);
	end

	// Restore the quotient sign and pick the final word
	assign quo     = qd_c[DW][WIDTH-1:0];
	assign div_res = ctl_c[DW].neg ? WIDTH'(0) - quo : quo;
	assign res     = ctl_c[DW].is_div ? (ctl_c[DW].dz ? '0 : div_res) : early_c[DW];

	// Hold the output word until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv) begin
			out_valid_q <= ctl_c[DW].valid;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			result_q         <= res;
			divide_by_zero_q <= ctl_c[DW].dz;
		end
	end

	assign out_valid      = out_valid_q;
	assign result         = result_q;
	assign divide_by_zero = divide_by_zero_q;

`include "fixed_point_alu_top_assert.svh"

	`FPA_ASSERT(a_dz_zero, (out_valid && divide_by_zero) |-> (result == '0), "flagged word not zero")
	`FPA_ASSERT_NEXT(a_chain_hold, in_stall, $stable(qd_c[DW]) && $stable(ctl_c[DW]), "chain moved in stall")
	`FPA_ASSERT(a_valid_rise, $rose(out_valid) |-> $past(adv), "output rose without advance")

endmodule
